// ===== rtl/page_frame_replacement_fifo_lru_top_defines.svh =====
// Assertion macros used by the page frame replacement sequencer.
`ifndef PAGE_FRAME_REPLACEMENT_FIFO_LRU_TOP_DEFINES_SVH
`define PAGE_FRAME_REPLACEMENT_FIFO_LRU_TOP_DEFINES_SVH

// Clocked assertion on clk_i, silenced while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/pfr_pkg.sv =====
// Shared constants and types of the page frame replacement table.
package pfr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int AGE_W     = 16;
  localparam int SLOT_W    = 4;
  localparam int EVP_W     = 16;
  localparam int FAULT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = 2'd1;

  // Replacement policy codes.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam logic [CFG_DAT_W-1:0] FRAMES_RESET = 5'd4;

  // One finished access result.
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               ev_valid;
    logic [EVP_W-1:0]   ev_page;
    logic [FAULT_W-1:0] fault;
  } res_t;

endpackage

// ===== rtl/page_frame_replacement_fifo_lru_top.sv =====
// Top level of the FIFO/LRU page frame replacement table.
//
// Usage: one page number arrives per input beat on in_valid_i/in_stall_o and
// produces exactly one result beat on out_valid_o/out_stall_i, carrying the
// hit flag, the frame slot, the eviction flag and page, and the fault count.
// The table state lives in a synchronous memory with a registered read port.
// Each access makes two passes over the frames in use: a scan pass
// that looks for a hit, the lowest free frame and the oldest frame, and an
// update pass that reads, ages and writes every frame back. Each pass reads
// one frame per cycle through the memory read port. An access runs through
// the idle step that takes the page, the scan pass, the decision step, the
// update pass and the hand-off to the output register; the sequencer takes
// no new page until that hand-off is done.
// A finished result goes into an output register; the block takes the next
// page while that result waits, and only holds its last step while the
// output register is still full. Reset empties every frame, clears the fault
// count and sets four frames in FIFO mode; no clearing pass is needed, since
// valid marks in flip-flops hide the stale memory contents.
// Configuration beats are taken while the block is idle and no page is offered.
module page_frame_replacement_fifo_lru_top #(
  parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pfr_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [PAGE_BITS-1:0]          page_number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [pfr_pkg::SLOT_W-1:0]    frame_slot_o,
  output logic                          evicted_valid_o,
  output logic [pfr_pkg::EVP_W-1:0]     evicted_page_o,
  output logic [pfr_pkg::FAULT_W-1:0]   fault_total_o
);

  localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [pfr_pkg::CFG_DAT_W-1:0] frames_in_use_q, frames_in_use_d;
  logic                          policy_q, policy_d;
  logic [FIDX_W-1:0]             last_idx;
  logic                          idle;

  logic                          rd_en, wr_en;
  logic [FIDX_W-1:0]             rd_addr, wr_addr;
  logic [PAGE_BITS-1:0]          rd_page, wr_page;
  logic [pfr_pkg::AGE_W-1:0]     rd_age, wr_age;

  logic                          res_valid, res_ready;
  pfr_pkg::res_t                 res;
  logic                          out_valid_q, out_valid_d;
  pfr_pkg::res_t                 out_q;

  // A configuration beat never lands on the same edge as an accepted page.
  assign cfg_ready_o = idle && !in_valid_i;
  assign in_stall_o  = !idle;

  // Configuration writes; unknown indexes are dropped.
  always_comb begin
    frames_in_use_d = frames_in_use_q;
    policy_d        = policy_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pfr_pkg::REG_FRAMES_IN_USE: frames_in_use_d = cfg_data_i;
        pfr_pkg::REG_POLICY_MODE:   policy_d        = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A count of zero acts as one frame, and a count above the built depth as the depth.
  always_comb begin
    if (frames_in_use_q == '0) begin
      last_idx = '0;
    end else if (int'(frames_in_use_q) > MAX_FRAMES) begin
      last_idx = FIDX_W'(MAX_FRAMES - 1);
    end else begin
      last_idx = FIDX_W'(frames_in_use_q - 1'b1);
    end
  end

  pfr_frame_mem #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_page_o (rd_page),
    .rd_age_o  (rd_age),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_page_i (wr_page),
    .wr_age_i  (wr_age)
  );

  pfr_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .page_i      (page_number_i),
    .idle_o      (idle),
    .last_i      (last_idx),
    .policy_i    (policy_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_page_i   (rd_page),
    .rd_age_i    (rd_age),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_page_o   (wr_page),
    .wr_age_o    (wr_age),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: it takes a new result when empty or when its beat leaves.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= pfr_pkg::FRAMES_RESET;
      policy_q        <= pfr_pkg::POLICY_FIFO;
      out_valid_q     <= 1'b0;
    end else begin
      frames_in_use_q <= frames_in_use_d;
      policy_q        <= policy_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_q.hit;
  assign frame_slot_o    = out_q.slot;
  assign evicted_valid_o = out_q.ev_valid;
  assign evicted_page_o  = out_q.ev_page;
  assign fault_total_o   = out_q.fault;

endmodule

// ===== rtl/pfr_frame_mem.sv =====
// Frame table memory: page number and age per frame, one write and one registered read port.
module pfr_frame_mem #(
  parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS_DEF,
  localparam int FIDX_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [FIDX_W-1:0]        rd_addr_i,
  output logic [PAGE_BITS-1:0]     rd_page_o,
  output logic [pfr_pkg::AGE_W-1:0] rd_age_o,
  input  logic                     wr_en_i,
  input  logic [FIDX_W-1:0]        wr_addr_i,
  input  logic [PAGE_BITS-1:0]     wr_page_i,
  input  logic [pfr_pkg::AGE_W-1:0] wr_age_i
);

  localparam int ENT_W = PAGE_BITS + pfr_pkg::AGE_W;

  logic [ENT_W-1:0] mem_q [MAX_FRAMES];
  logic [ENT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_page_i, wr_age_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_page_o = rd_data_q[ENT_W-1:pfr_pkg::AGE_W];
  assign rd_age_o  = rd_data_q[pfr_pkg::AGE_W-1:0];

endmodule

// ===== rtl/pfr_ctrl.sv =====
// Access sequencer: scans the frame table, picks the slot and ages every frame in use.
`include "page_frame_replacement_fifo_lru_top_defines.svh"

module pfr_ctrl #(
  parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS_DEF,
  localparam int FIDX_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [PAGE_BITS-1:0]      page_i,
  output logic                      idle_o,
  input  logic [FIDX_W-1:0]         last_i,
  input  logic                      policy_i,
  output logic                      rd_en_o,
  output logic [FIDX_W-1:0]         rd_addr_o,
  input  logic [PAGE_BITS-1:0]      rd_page_i,
  input  logic [pfr_pkg::AGE_W-1:0] rd_age_i,
  output logic                      wr_en_o,
  output logic [FIDX_W-1:0]         wr_addr_o,
  output logic [PAGE_BITS-1:0]      wr_page_o,
  output logic [pfr_pkg::AGE_W-1:0] wr_age_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output pfr_pkg::res_t             res_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [FIDX_W-1:0]            i_q, i_d;
  logic                         iss_done_q, iss_done_d;
  logic                         rsp_v_q, rsp_v_d;
  logic [FIDX_W-1:0]            rsp_idx_q, rsp_idx_d;
  logic [MAX_FRAMES-1:0]        frame_valid_q, frame_valid_d;
  logic [pfr_pkg::FAULT_W-1:0]  fault_q, fault_d, fault_inc;
  logic                         hit_f_q, hit_f_d;
  logic                         free_f_q, free_f_d;

  logic [PAGE_BITS-1:0]         pg_q, pg_d;
  logic [FIDX_W-1:0]            hit_idx_q, hit_idx_d;
  logic [FIDX_W-1:0]            free_idx_q, free_idx_d;
  logic [pfr_pkg::AGE_W-1:0]    best_age_q, best_age_d;
  logic [FIDX_W-1:0]            best_idx_q, best_idx_d;
  logic [PAGE_BITS-1:0]         best_page_q, best_page_d;
  logic [FIDX_W-1:0]            slot_q, slot_d, slot_sel;
  logic                         miss_q, miss_d;
  logic                         touch_q, touch_d;
  pfr_pkg::res_t                res_q, res_d;

  logic                         rsp_vld;
  logic [pfr_pkg::AGE_W-1:0]    age_inc;

  assign rsp_vld   = frame_valid_q[rsp_idx_q];
  assign age_inc   = (rd_age_i == pfr_pkg::AGE_MAX) ? rd_age_i : rd_age_i + 1'b1;
  assign fault_inc = (fault_q == pfr_pkg::FAULT_MAX) ? fault_q : fault_q + 1'b1;
  assign slot_sel  = free_f_q ? free_idx_q : best_idx_q;

  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    iss_done_d    = iss_done_q;
    frame_valid_d = frame_valid_q;
    fault_d       = fault_q;
    hit_f_d       = hit_f_q;
    free_f_d      = free_f_q;
    pg_d          = pg_q;
    hit_idx_d     = hit_idx_q;
    free_idx_d    = free_idx_q;
    best_age_d    = best_age_q;
    best_idx_d    = best_idx_q;
    best_page_d   = best_page_q;
    slot_d        = slot_q;
    miss_d        = miss_q;
    touch_d       = touch_q;
    res_d         = res_q;
    rd_en_o       = 1'b0;
    wr_en_o       = 1'b0;
    wr_page_o     = rd_page_i;
    wr_age_o      = age_inc;
    res_valid_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pg_d       = page_i;
          i_d        = '0;
          iss_done_d = 1'b0;
          hit_f_d    = 1'b0;
          free_f_d   = 1'b0;
          best_age_d = '0;
          best_idx_d = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!iss_done_q) begin
          rd_en_o = 1'b1;
          i_d     = i_q + 1'b1;
          if (i_q == last_i) begin
            iss_done_d = 1'b1;
          end
        end
        if (rsp_v_q) begin
          if (!hit_f_q && rsp_vld && (rd_page_i == pg_q)) begin
            hit_f_d   = 1'b1;
            hit_idx_d = rsp_idx_q;
          end
          if (!free_f_q && !rsp_vld) begin
            free_f_d   = 1'b1;
            free_idx_d = rsp_idx_q;
          end
          // Ties move to the later frame, so the highest index wins.
          if (rsp_vld && (rd_age_i >= best_age_q)) begin
            best_age_d  = rd_age_i;
            best_idx_d  = rsp_idx_q;
            best_page_d = rd_page_i;
          end
          if (rsp_idx_q == last_i) begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        i_d        = '0;
        iss_done_d = 1'b0;
        state_d    = S_UPD;
        if (hit_f_q) begin
          slot_d         = hit_idx_q;
          miss_d         = 1'b0;
          touch_d        = (policy_i == pfr_pkg::POLICY_LRU);
          res_d.hit      = 1'b1;
          res_d.slot     = pfr_pkg::SLOT_W'(hit_idx_q);
          res_d.ev_valid = 1'b0;
          res_d.ev_page  = '0;
          res_d.fault    = fault_q;
        end else begin
          fault_d                 = fault_inc;
          slot_d                  = slot_sel;
          miss_d                  = 1'b1;
          touch_d                 = 1'b1;
          frame_valid_d[slot_sel] = 1'b1;
          res_d.hit               = 1'b0;
          res_d.slot              = pfr_pkg::SLOT_W'(slot_sel);
          res_d.ev_valid          = !free_f_q;
          res_d.ev_page           = free_f_q ? '0 : pfr_pkg::EVP_W'(best_page_q);
          res_d.fault             = fault_inc;
        end
      end
      S_UPD: begin
        if (!iss_done_q) begin
          rd_en_o = 1'b1;
          i_d     = i_q + 1'b1;
          if (i_q == last_i) begin
            iss_done_d = 1'b1;
          end
        end
        if (rsp_v_q) begin
          wr_en_o = 1'b1;
          if (rsp_idx_q == slot_q) begin
            if (miss_q) begin
              wr_page_o = pg_q;
            end
            // A fresh or touched frame restarts at zero and is then aged once.
            if (touch_q) begin
              wr_age_o = pfr_pkg::AGE_W'(1);
            end
          end
          if (rsp_idx_q == last_i) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_v_d   = rd_en_o;
    rsp_idx_d = i_q;
  end

  assign rd_addr_o = i_q;
  assign wr_addr_o = rsp_idx_q;
  assign idle_o    = (state_q == S_IDLE);
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      i_q           <= '0;
      iss_done_q    <= 1'b0;
      rsp_v_q       <= 1'b0;
      rsp_idx_q     <= '0;
      frame_valid_q <= '0;
      fault_q       <= '0;
      hit_f_q       <= 1'b0;
      free_f_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      i_q           <= i_d;
      iss_done_q    <= iss_done_d;
      rsp_v_q       <= rsp_v_d;
      rsp_idx_q     <= rsp_idx_d;
      frame_valid_q <= frame_valid_d;
      fault_q       <= fault_d;
      hit_f_q       <= hit_f_d;
      free_f_q      <= free_f_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q        <= pg_d;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    best_age_q  <= best_age_d;
    best_idx_q  <= best_idx_d;
    best_page_q <= best_page_d;
    slot_q      <= slot_d;
    miss_q      <= miss_d;
    touch_q     <= touch_d;
    res_q       <= res_d;
  end

  `ASSERT_CLK(a_fault_mono, fault_q >= $past(fault_q), "fault count went down")
  `ASSERT_CLK(a_valid_sticky, (frame_valid_q & $past(frame_valid_q)) == $past(frame_valid_q), "a frame lost its valid mark")
  `ASSERT_IMPL(a_rw_apart, wr_en_o && rd_en_o, wr_addr_o != rd_addr_o, "read and write hit the same frame")
  `ASSERT_NEXT(a_fill_marks, (state_q == S_DECIDE) && !hit_f_q, frame_valid_q[slot_q], "filled frame not marked valid")
  `ASSERT_IMPL(a_hit_no_evict, res_valid_o && res_o.hit, !res_o.ev_valid, "hit reported an eviction")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the FIFO/LRU page frame replacement table.
`timescale 1ns / 100ps

module tb_top;

  // Register indexes that the block does not implement; writes to them must be ignored.
  localparam logic [pfr_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [pfr_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int unsigned PAGE_MAX  = (1 << pfr_pkg::PAGE_BITS_DEF) - 1;
  localparam int unsigned PHASES    = 13;
  localparam int unsigned PHASE_LEN = 150;
  // The tail waits out the slowest access at sixteen frames.
  localparam int unsigned TAIL_CYCLES = 2 * pfr_pkg::MAX_FRAMES_DEF + 5 + 8;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pfr_pkg::CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [15:0]                   page_number_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          hit_o;
  logic [pfr_pkg::SLOT_W-1:0]    frame_slot_o;
  logic                          evicted_valid_o;
  logic [pfr_pkg::EVP_W-1:0]     evicted_page_o;
  logic [pfr_pkg::FAULT_W-1:0]   fault_total_o;

  page_frame_replacement_fifo_lru_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .frame_slot_o    (frame_slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

  // 8 ns clock period.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the frame table. It is updated at every accepted input beat
  // and produces the result beat that the block must return for that access.
  // ---------------------------------------------------------------------------
  logic [15:0]                   tbl_page  [pfr_pkg::MAX_FRAMES_DEF];
  logic                          tbl_valid [pfr_pkg::MAX_FRAMES_DEF];
  logic [pfr_pkg::AGE_W-1:0]     tbl_age   [pfr_pkg::MAX_FRAMES_DEF];
  logic [pfr_pkg::FAULT_W-1:0]   fault_cnt;
  logic [pfr_pkg::CFG_DAT_W-1:0] cfg_frames;
  logic                          cfg_policy;

  pfr_pkg::res_t expected_access_q[$];
  int            error_count;

  // Knobs that the test tasks turn to vary the idle pattern on each side.
  bit idle_on;
  bit stall_on;

  // A frame count of zero behaves as one, and anything above the built depth as the depth.
  function automatic int unsigned active_frames(input logic [pfr_pkg::CFG_DAT_W-1:0] count);
    if (count == 0) return 1;
    if (count > pfr_pkg::MAX_FRAMES_DEF) return pfr_pkg::MAX_FRAMES_DEF;
    return 32'(count);
  endfunction

  function automatic pfr_pkg::res_t access_table(input logic [15:0] pg);
    int unsigned   n;
    int unsigned   slot;
    int unsigned   i;
    bit            found;
    bit            have_free;
    pfr_pkg::res_t r;
    n         = active_frames(cfg_frames);
    r         = '0;
    slot      = 0;
    found     = 1'b0;
    have_free = 1'b0;
    // The lowest matching valid frame wins when a page sits in more than one frame.
    for (i = 0; i < n; i++) begin
      if (!found && tbl_valid[i] && tbl_page[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (cfg_policy == pfr_pkg::POLICY_LRU) tbl_age[slot] = '0;
    end else begin
      if (fault_cnt != pfr_pkg::FAULT_MAX) fault_cnt++;
      for (i = 0; i < n; i++) begin
        if (!have_free && !tbl_valid[i]) begin
          slot      = i;
          have_free = 1'b1;
        end
      end
      // No free frame: evict the oldest one, with ties going to the higher index.
      if (!have_free) begin
        slot = 0;
        for (i = 0; i < n; i++) begin
          if (tbl_age[i] >= tbl_age[slot]) slot = i;
        end
        r.ev_valid = 1'b1;
        r.ev_page  = tbl_page[slot];
      end
      tbl_page[slot]  = pg;
      tbl_valid[slot] = 1'b1;
      tbl_age[slot]   = '0;
    end
    // Every frame in use ages, including empty ones; frames beyond the count are frozen.
    for (i = 0; i < n; i++) begin
      if (tbl_age[i] != pfr_pkg::AGE_MAX) tbl_age[i]++;
    end
    r.hit  = found;
    r.slot = slot[pfr_pkg::SLOT_W-1:0];
    r.fault = fault_cnt;
    return r;
  endfunction

  // Most gaps are short, a few are long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input and configuration drivers.
  // ---------------------------------------------------------------------------

  // Presents one page; valid stays high after acceptance so that back-to-back
  // beats need no extra edge. The caller lowers valid when it stops sending.
  task automatic send_page(input logic [15:0] pg);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    page_number_i <= pg;
    do @(posedge clk_i); while (in_stall_o);
    expected_access_q.push_back(access_table(pg));
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_access_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register; valid is left high for the caller to release.
  task automatic write_reg(input logic [pfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pfr_pkg::CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pfr_pkg::REG_FRAMES_IN_USE: cfg_frames = data;
      pfr_pkg::REG_POLICY_MODE:   cfg_policy = data[0];
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic [pfr_pkg::CFG_DAT_W-1:0] frames, input logic policy);
    wait_idle();
    write_reg(pfr_pkg::REG_FRAMES_IN_USE, frames);
    write_reg(pfr_pkg::REG_POLICY_MODE, {{(pfr_pkg::CFG_DAT_W-1){1'b0}}, policy});
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random backpressure and the result checker.
  // ---------------------------------------------------------------------------
  int unsigned stall_left;

  // Each stall level is held for a random span; with stall_on clear the output never stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      out_stall_i <= stall_on && ($urandom_range(0, 99) < 35);
      stall_left = pick_gap();
    end else begin
      stall_left--;
    end
  end

  task automatic log_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) log_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // Every result beat is matched against the oldest predicted access.
  always @(posedge clk_i) begin
    pfr_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_access_q.size() == 0) begin
        log_mismatch("result beat with no access outstanding");
      end else begin
        want = expected_access_q.pop_front();
        check_field("hit", 64'(want.hit), 64'(hit_o));
        check_field("frame_slot", 64'(want.slot), 64'(frame_slot_o));
        check_field("evicted_valid", 64'(want.ev_valid), 64'(evicted_valid_o));
        check_field("evicted_page", 64'(want.ev_page), 64'(evicted_page_o));
        check_field("fault_total", 64'(want.fault), 64'(fault_total_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Reset settings: four frames, FIFO. Fill all four with pages that include both extremes,
  // hit the first one, then force an eviction of the frame loaded first.
  task automatic test_fill_and_evict();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h1234);
    send_page(16'h8000);
    send_page(16'h0000);
    send_page(16'h0005);
  endtask

  // In LRU mode a hit makes the frame young again, so the other page is evicted.
  task automatic test_lru_hit_refresh();
    configure(5'd2, pfr_pkg::POLICY_LRU);
    send_page(16'h0011);
    send_page(16'h0022);
    send_page(16'h0011);
    send_page(16'h0033);
    // A load, a hit and a miss in FIFO mode evict by load order instead.
    configure(5'd2, pfr_pkg::POLICY_FIFO);
    send_page(16'h0044);
    send_page(16'h0044);
    send_page(16'h0055);
  endtask

  // A count of zero acts as one frame; a count above the depth acts as the full depth.
  task automatic test_frame_count_limits();
    configure(5'd0, pfr_pkg::POLICY_FIFO);
    send_page(16'h4444);
    send_page(16'h5555);
    configure(5'd31, pfr_pkg::POLICY_LRU);
    send_page(16'h4444);
    send_page(16'h6666);
    configure(5'd16, pfr_pkg::POLICY_FIFO);
    send_page(16'h6666);
  endtask

  // Shrinking the count hides high frames; growing it again can leave one page in two
  // frames, and the lookup must pick the lower one.
  task automatic test_duplicate_pages();
    send_page(16'h7777);
    configure(5'd1, pfr_pkg::POLICY_FIFO);
    send_page(16'h7777);
    configure(5'd16, pfr_pkg::POLICY_FIFO);
    send_page(16'h7777);
  endtask

  // Writes to unimplemented indexes must leave both registers alone.
  task automatic test_spare_registers();
    wait_idle();
    write_reg(REG_SPARE_2, 5'h1F);
    write_reg(REG_SPARE_3, 5'h00);
    cfg_valid_i <= 1'b0;
    send_page(16'h7777);
    send_page(16'hA5A5);
  endtask

  // ---------------------------------------------------------------------------
  // Random accesses. Each phase picks a table size and policy and draws most pages
  // from a working set sized around the frame count, so that hits, refreshes and
  // evictions all happen often; the rest are arbitrary or extreme page numbers.
  // ---------------------------------------------------------------------------
  logic [15:0] work_set[$];

  function automatic logic [15:0] pick_page();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return work_set[$urandom_range(0, (work_set.size() > 4) ? 3 : work_set.size() - 1)];
    if (roll < 85) return work_set[$urandom_range(0, work_set.size() - 1)];
    if (roll < 95) return 16'($urandom_range(0, PAGE_MAX));
    case ($urandom_range(0, 2))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'h1 << $urandom_range(0, 15);
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [pfr_pkg::CFG_DAT_W-1:0] frames;
    logic                          policy;
    int unsigned                   n;
    int unsigned                   k;
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      // Early phases hit the count extremes, later ones draw freely.
      case (ph)
        0: frames = 5'd1;
        1: frames = 5'd16;
        2: frames = 5'd0;
        3: frames = 5'd31;
        default: frames = (ph % 3 == 0) ? pfr_pkg::CFG_DAT_W'($urandom_range(17, 31))
                                        : pfr_pkg::CFG_DAT_W'($urandom_range(1, 16));
      endcase
      policy = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      configure(frames, policy);
      n = active_frames(frames);
      work_set.delete();
      repeat ($urandom_range(1, 2 * n + 3)) begin
        work_set.push_back(16'($urandom_range(0, PAGE_MAX)));
      end
      for (k = 0; k < PHASE_LEN; k++) begin
        // Re-roll the idle pattern now and then so quiet stretches show up too.
        if (k % 40 == 0) begin
          idle_on  = ($urandom_range(0, 3) != 0);
          stall_on = ($urandom_range(0, 3) != 0);
        end
        send_page(pick_page());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    error_count = 0;
    idle_on     = 1'b1;
    stall_on    = 1'b1;
    stall_left  = 0;
    cfg_frames  = pfr_pkg::FRAMES_RESET;
    cfg_policy  = pfr_pkg::POLICY_FIFO;
    fault_cnt   = '0;
    for (int i = 0; i < pfr_pkg::MAX_FRAMES_DEF; i++) begin
      tbl_page[i]  = '0;
      tbl_valid[i] = 1'b0;
      tbl_age[i]   = '0;
    end

    // Reset is released on a rising edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_and_evict();
    test_lru_hit_refresh();
    test_frame_count_limits();
    test_duplicate_pages();
    test_spare_registers();
    test_random_traffic();

    // Drain, then give the block time to show any stray result beat.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
